FILE: rtl/core/crcfp_pkg.sv
// Package for the CRC16 frame parser.
// Holds sizing constants, CRC constants, status codes and register indexes.
// No dependencies.
package crcfp_pkg;

   // Largest payload kept in the store (1 to 63, so the count fits rsp_payload_count)
   localparam int MAX_PAYLOAD = 32;
   localparam int PAY_AW      = $clog2((MAX_PAYLOAD > 1) ? MAX_PAYLOAD : 2);

   // Frame layout and counter limits
   localparam logic [8:0] INDEX_MAX   = 9'd511;
   localparam logic [8:0] MIN_FRAME   = 9'd7;
   localparam logic [7:0] HDR_OVERHEAD = 8'd5;

   // CRC16-MODBUS, reflected form
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Frame status codes
   typedef logic [2:0] status_type;
   localparam status_type STATUS_OK       = 3'd0;
   localparam status_type STATUS_SHORT    = 3'd1;
   localparam status_type STATUS_HEADER   = 3'd2;
   localparam status_type STATUS_LENGTH   = 3'd3;
   localparam status_type STATUS_TOO_LONG = 3'd4;
   localparam status_type STATUS_CRC      = 3'd5;

   // Register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_HEADER_FIRST  = 2'd0;
   localparam csr_index_type CSR_HEADER_SECOND = 2'd1;

endpackage

FILE: rtl/core/crcfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the payload store; no dependencies.
module crcfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/core/crc16_frame_parser.sv
// CRC16 frame parser, top level.
// Depends on crcfp_pkg and crcfp_ram.
//
// Usage:
//   The req channel takes one frame byte per word (req_rx_byte) with
//   req_frame_end high on the final byte. Layout: H0 H1 LEN TYPE DST
//   PAYLOAD CRC_HI CRC_LO; the CRC16-MODBUS covers LEN up to the last
//   payload byte. The rsp channel returns one word for a rejected frame or
//   an empty payload, else one word per payload byte; rsp_run_last marks
//   the final word of a frame. The csr port writes the two expected header
//   bytes and must only be used while the block is idle.
// Sequence:
//   Bytes 0 to 3 of a frame start no CRC work. Every later byte up to the
//   511th is followed by 8 steps of the bit-serial CRC unit, which folds
//   in the byte received two words earlier, and no byte is taken until
//   they end; bytes past the saturated count get no CRC steps. After the
//   final byte the checks run, and each payload word is then a RAM read,
//   then a load of the output register.
// Reset and stalls:
//   Reset clears the frame state and loads header bytes 0xAA and 0x55; the
//   payload RAM is not cleared. A stalled rsp side holds the output
//   register; parsing of the next frame goes on until a new word needs it.
module crc16_frame_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_rx_byte,
   input  logic                     req_frame_end,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output crcfp_pkg::status_type    rsp_frame_status,
   output logic [7:0]               rsp_frame_kind,
   output logic [7:0]               rsp_dest_id,
   output logic [5:0]               rsp_payload_count,
   output logic [7:0]               rsp_payload_byte,
   output logic                     rsp_payload_present,
   output logic [15:0]              rsp_received_crc,
   output logic                     rsp_run_last,
   input  logic                     csr_wr_en,
   input  crcfp_pkg::csr_index_type csr_index,
   input  logic [7:0]               csr_wdata
);

   import crcfp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CRC,
      S_JUDGE,
      S_READ,
      S_LOAD
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  bit_cnt_ff, bit_cnt_in;
   logic        end_ff, end_in;
   logic [8:0]  byte_index_ff, byte_index_in;
   logic        header_good_ff, header_good_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  dest_ff, dest_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] capture_ff, capture_in;
   logic [7:0]  hdr0_ff, hdr0_in;
   logic [7:0]  hdr1_ff, hdr1_in;
   logic [7:0]  k_ff, k_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  out_status_ff, out_status_in;
   logic [7:0]  out_kind_ff, out_kind_in;
   logic [7:0]  out_dest_ff, out_dest_in;
   logic [5:0]  out_count_ff, out_count_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_present_ff, out_present_in;
   logic [15:0] out_crc_ff, out_crc_in;
   logic        out_last_ff, out_last_in;

   logic              in_acc;
   logic              feed;
   logic              slot_free;
   logic [7:0]        plen;
   logic [8:0]        store_off;
   logic              store_we;
   logic [PAY_AW-1:0] store_waddr;
   logic [7:0]        store_rdata;
   status_type        status;

   // Handshake
   assign req_ready = (state_ff == S_IDLE);
   assign in_acc    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Feed the byte two places back once it is known not to be CRC
   assign feed = (byte_index_ff >= 9'd4) && (byte_index_ff < INDEX_MAX);

   // Payload store write
   assign store_off   = byte_index_ff - 9'd5;
   assign store_we    = in_acc && (byte_index_ff >= 9'd5) &&
                        (store_off < 9'(MAX_PAYLOAD));
   assign store_waddr = store_off[PAY_AW-1:0];

   crcfp_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (req_rx_byte),
      .rd_addr (k_ff[PAY_AW-1:0]),
      .rd_data (store_rdata)
   );

   // Frame checks in priority order
   assign plen = length_ff - HDR_OVERHEAD;
   always_comb begin
      if (byte_index_ff < MIN_FRAME) begin
         status = STATUS_SHORT;
      end else if (!header_good_ff) begin
         status = STATUS_HEADER;
      end else if (({1'b0, length_ff} + 9'd2) != byte_index_ff) begin
         status = STATUS_LENGTH;
      end else if ({1'b0, plen} > 9'(MAX_PAYLOAD)) begin
         status = STATUS_TOO_LONG;
      end else if (crc_ff != capture_ff) begin
         status = STATUS_CRC;
      end else begin
         status = STATUS_OK;
      end
   end

   // Next-state logic
   always_comb begin
      state_in       = state_ff;
      bit_cnt_in     = bit_cnt_ff;
      end_in         = end_ff;
      byte_index_in  = byte_index_ff;
      header_good_in = header_good_ff;
      length_in      = length_ff;
      kind_in        = kind_ff;
      dest_in        = dest_ff;
      crc_in         = crc_ff;
      capture_in     = capture_ff;
      hdr0_in        = hdr0_ff;
      hdr1_in        = hdr1_ff;
      k_in           = k_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      out_status_in  = out_status_ff;
      out_kind_in    = out_kind_ff;
      out_dest_in    = out_dest_ff;
      out_count_in   = out_count_ff;
      out_byte_in    = out_byte_ff;
      out_present_in = out_present_ff;
      out_crc_in     = out_crc_ff;
      out_last_in    = out_last_ff;

      // Configuration writes; other indexes drop
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:  hdr0_in = csr_wdata;
            CSR_HEADER_SECOND: hdr1_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (in_acc) begin
               if (byte_index_ff == 9'd0 && req_rx_byte != hdr0_ff) begin
                  header_good_in = 1'b0;
               end
               if (byte_index_ff == 9'd1 && req_rx_byte != hdr1_ff) begin
                  header_good_in = 1'b0;
               end
               if (byte_index_ff == 9'd2) length_in = req_rx_byte;
               if (byte_index_ff == 9'd3) kind_in = req_rx_byte;
               if (byte_index_ff == 9'd4) dest_in = req_rx_byte;
               capture_in = {capture_ff[7:0], req_rx_byte};
               if (byte_index_ff < INDEX_MAX) begin
                  byte_index_in = byte_index_ff + 9'd1;
               end
               end_in = req_frame_end;
               if (feed) begin
                  crc_in     = crc_ff ^ {8'h00, capture_ff[15:8]};
                  bit_cnt_in = 3'd0;
                  state_in   = S_CRC;
               end else if (req_frame_end) begin
                  state_in = S_JUDGE;
               end
            end
         end

         // One shift step of the CRC unit per cycle
         S_CRC: begin
            crc_in     = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
            bit_cnt_in = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd7) begin
               state_in = end_ff ? S_JUDGE : S_IDLE;
            end
         end

         S_JUDGE: begin
            if (slot_free) begin
               if (status != STATUS_OK || plen == 8'd0) begin
                  rsp_valid_in   = 1'b1;
                  out_status_in  = status;
                  out_byte_in    = 8'h00;
                  out_present_in = 1'b0;
                  out_count_in   = 6'd0;
                  out_last_in    = 1'b1;
                  if (status == STATUS_OK) begin
                     out_kind_in = kind_ff;
                     out_dest_in = dest_ff;
                     out_crc_in  = capture_ff;
                  end else begin
                     out_kind_in = 8'h00;
                     out_dest_in = 8'h00;
                     out_crc_in  = 16'h0000;
                  end
                  state_in = S_IDLE;
               end else begin
                  k_in     = 8'd0;
                  state_in = S_READ;
               end
            end
         end

         // Store read issued at k; data is ready next cycle
         S_READ: begin
            state_in = S_LOAD;
         end

         S_LOAD: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               out_status_in  = STATUS_OK;
               out_kind_in    = kind_ff;
               out_dest_in    = dest_ff;
               out_count_in   = plen[5:0];
               out_byte_in    = store_rdata;
               out_present_in = 1'b1;
               out_crc_in     = capture_ff;
               out_last_in    = ((k_ff + 8'd1) == plen);
               if ((k_ff + 8'd1) == plen) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 8'd1;
                  state_in = S_READ;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Return per-frame state to reset values after the last word
      if ((state_ff == S_JUDGE || state_ff == S_LOAD) && state_in == S_IDLE) begin
         byte_index_in  = 9'd0;
         header_good_in = 1'b1;
         length_in      = 8'h00;
         kind_in        = 8'h00;
         dest_in        = 8'h00;
         crc_in         = CRC_INIT;
         capture_in     = 16'h0000;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         bit_cnt_ff     <= 3'd0;
         end_ff         <= 1'b0;
         byte_index_ff  <= 9'd0;
         header_good_ff <= 1'b1;
         length_ff      <= 8'h00;
         kind_ff        <= 8'h00;
         dest_ff        <= 8'h00;
         crc_ff         <= CRC_INIT;
         capture_ff     <= 16'h0000;
         hdr0_ff        <= 8'hAA;
         hdr1_ff        <= 8'h55;
         k_ff           <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bit_cnt_ff     <= bit_cnt_in;
         end_ff         <= end_in;
         byte_index_ff  <= byte_index_in;
         header_good_ff <= header_good_in;
         length_ff      <= length_in;
         kind_ff        <= kind_in;
         dest_ff        <= dest_in;
         crc_ff         <= crc_in;
         capture_ff     <= capture_in;
         hdr0_ff        <= hdr0_in;
         hdr1_ff        <= hdr1_in;
         k_ff           <= k_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      out_status_ff  <= out_status_in;
      out_kind_ff    <= out_kind_in;
      out_dest_ff    <= out_dest_in;
      out_count_ff   <= out_count_in;
      out_byte_ff    <= out_byte_in;
      out_present_ff <= out_present_in;
      out_crc_ff     <= out_crc_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_status    = out_status_ff;
   assign rsp_frame_kind      = out_kind_ff;
   assign rsp_dest_id         = out_dest_ff;
   assign rsp_payload_count   = out_count_ff;
   assign rsp_payload_byte    = out_byte_ff;
   assign rsp_payload_present = out_present_ff;
   assign rsp_received_crc    = out_crc_ff;
   assign rsp_run_last        = out_last_ff;

`ifndef NO_ASSERTIONS
   // The final byte always leads to a busy cycle for CRC or checks
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_frame_end) |=> !req_ready)
      else $error("block ready right after final byte");

   // A payload word only comes from an accepted frame
   a_present_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload_present) |-> (rsp_frame_status == STATUS_OK))
      else $error("payload word on rejected frame");

   // A rejected frame gives exactly one word with cleared fields
   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_status != STATUS_OK) |->
      (rsp_run_last && rsp_frame_kind == 8'h00 && rsp_received_crc == 16'h0000))
      else $error("rejected frame word malformed");

   // Store reads stay inside the payload of the frame
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (k_ff < plen))
      else $error("payload read beyond frame length");
`endif

endmodule
